>>> rtl/nmsd_pkg.sv
// Shared types and constants for the nearest model squared distance core.
`timescale 1ns / 1ps
`default_nettype none

package nmsd_pkg;

   localparam int DIST_BITS = 48;
   localparam int IDX_BITS  = 4;

   typedef logic [DIST_BITS-1:0] dist_type;
   typedef logic [IDX_BITS-1:0]  idx_type;

   localparam dist_type DIST_MAX = '1;

   // Per-request control that travels alongside the squared difference.
   typedef struct packed {
      idx_type idx;
      logic    last_model;
      logic    last_all;
   } ctrl_type;

endpackage

`default_nettype wire

>>> rtl/nmsd_req_if.sv
// Request channel interface: one query/model frequency pair per request.
`timescale 1ns / 1ps
`default_nettype none

interface nmsd_req_if #(
   parameter int FREQ_BITS = 16
);
   import nmsd_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [FREQ_BITS-1:0] query_freq;
   logic [FREQ_BITS-1:0] model_freq;
   idx_type              model_index;
   logic                 last_of_model;
   logic                 last_of_all;

   modport source (
      output valid, query_freq, model_freq, model_index, last_of_model, last_of_all,
      input  ready
   );

   modport sink (
      input  valid, query_freq, model_freq, model_index, last_of_model, last_of_all,
      output ready
   );

endinterface

`default_nettype wire

>>> rtl/nmsd_rsp_if.sv
// Response channel interface: per-model distance and best model so far.
`timescale 1ns / 1ps
`default_nettype none

interface nmsd_rsp_if;
   import nmsd_pkg::*;

   logic     valid;
   logic     ready;
   dist_type model_distance;
   idx_type  finished_model;
   idx_type  best_model;
   logic     best_found;
   logic     final_res;

   modport source (
      output valid, model_distance, finished_model, best_model, best_found, final_res,
      input  ready
   );

   modport sink (
      input  valid, model_distance, finished_model, best_model, best_found, final_res,
      output ready
   );

endinterface

`default_nettype wire

>>> rtl/nmsd_square.sv
// Input register and absolute-difference squaring stage.
`timescale 1ns / 1ps
`default_nettype none

module nmsd_square #(
   parameter int FREQ_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   nmsd_req_if.sink                       req_ch,
   output logic                           sq_valid,
   input  wire logic                      sq_ready,
   output logic [2*FREQ_BITS-1:0]         sq_data,
   output nmsd_pkg::ctrl_type             sq_ctrl
);
   import nmsd_pkg::*;

   localparam int SQ_BITS = 2 * FREQ_BITS;

   logic                 s1_valid_ff;
   logic [FREQ_BITS-1:0] s1_q_ff;
   logic [FREQ_BITS-1:0] s1_m_ff;
   ctrl_type             s1_ctrl_ff;
   logic                 sq_valid_ff;
   logic [SQ_BITS-1:0]   sq_ff;
   logic [SQ_BITS-1:0]   sq_in;
   ctrl_type             sq_ctrl_ff;
   logic [FREQ_BITS-1:0] diff;
   logic                 s1_go;
   logic                 accept;

   assign s1_go        = s1_valid_ff && (!sq_valid_ff || sq_ready);
   assign req_ch.ready = !s1_valid_ff || s1_go;
   assign accept       = req_ch.valid && req_ch.ready;

   assign diff  = (s1_q_ff >= s1_m_ff) ? (s1_q_ff - s1_m_ff) : (s1_m_ff - s1_q_ff);
   assign sq_in = SQ_BITS'(diff) * SQ_BITS'(diff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         sq_valid_ff <= 1'b0;
      end else begin
         if (req_ch.ready) begin
            s1_valid_ff <= req_ch.valid;
         end
         if (!sq_valid_ff || sq_ready) begin
            sq_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_q_ff               <= req_ch.query_freq;
         s1_m_ff               <= req_ch.model_freq;
         s1_ctrl_ff.idx        <= req_ch.model_index;
         s1_ctrl_ff.last_model <= req_ch.last_of_model;
         s1_ctrl_ff.last_all   <= req_ch.last_of_all;
      end
      if (s1_go) begin
         sq_ff      <= sq_in;
         sq_ctrl_ff <= s1_ctrl_ff;
      end
   end

   assign sq_valid = sq_valid_ff;
   assign sq_data  = sq_ff;
   assign sq_ctrl  = sq_ctrl_ff;

endmodule

`default_nettype wire

>>> rtl/nmsd_accum.sv
// Saturating accumulator, best-model tracking and response register.
`timescale 1ns / 1ps
`default_nettype none

module nmsd_accum #(
   parameter int FREQ_BITS = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      sq_valid,
   output logic                           sq_ready,
   input  wire logic [2*FREQ_BITS-1:0]    sq_data,
   input  wire nmsd_pkg::ctrl_type        sq_ctrl,
   input  wire nmsd_pkg::dist_type        limit,
   nmsd_rsp_if.source                     rsp_ch
);
   import nmsd_pkg::*;

   localparam int WIDE_BITS = DIST_BITS + 1;

   dist_type               sum_ff;
   dist_type               sum_in;
   logic [WIDE_BITS-1:0]   sum_wide;
   dist_type               best_dist_ff;
   idx_type                best_idx_ff;
   logic                   best_valid_ff;
   logic                   rsp_valid_ff;
   dist_type               rsp_dist_ff;
   idx_type                rsp_fin_ff;
   idx_type                rsp_best_ff;
   logic                   rsp_found_ff;
   logic                   rsp_final_ff;
   idx_type                best_in;
   logic                   close;
   logic                   out_free;
   logic                   sq_go;
   logic                   better;

   assign close    = sq_ctrl.last_model || sq_ctrl.last_all;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign sq_go    = sq_valid && (!close || out_free);
   assign sq_ready = !sq_valid || sq_go;

   assign sum_wide = {1'b0, sum_ff} + WIDE_BITS'(sq_data);
   assign sum_in   = sum_wide[DIST_BITS] ? DIST_MAX : sum_wide[DIST_BITS-1:0];

   assign better  = close && (sum_in < limit) && (!best_valid_ff || sum_in < best_dist_ff);
   assign best_in = better ? sq_ctrl.idx : (best_valid_ff ? best_idx_ff : '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff        <= '0;
         best_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (sq_go) begin
            sum_ff <= close ? '0 : sum_in;
            if (close && sq_ctrl.last_all) begin
               best_valid_ff <= 1'b0;
            end else if (better) begin
               best_valid_ff <= 1'b1;
            end
         end
         if (out_free) begin
            rsp_valid_ff <= sq_valid && close;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sq_go && better) begin
         best_dist_ff <= sum_in;
         best_idx_ff  <= sq_ctrl.idx;
      end
      if (sq_go && close) begin
         rsp_dist_ff  <= sum_in;
         rsp_fin_ff   <= sq_ctrl.idx;
         rsp_best_ff  <= best_in;
         rsp_found_ff <= better || best_valid_ff;
         rsp_final_ff <= sq_ctrl.last_all;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.model_distance = rsp_dist_ff;
   assign rsp_ch.finished_model = rsp_fin_ff;
   assign rsp_ch.best_model     = rsp_best_ff;
   assign rsp_ch.best_found     = rsp_found_ff;
   assign rsp_ch.final_res      = rsp_final_ff;

   a_best_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.best_found |-> rsp_ch.best_model == '0)
      else $error("best_model nonzero without best_found");

   a_close_rsp: assert property (@(posedge clock) disable iff (reset)
      sq_go && close |=> rsp_ch.valid)
      else $error("closing request produced no response");

   a_seq_clear: assert property (@(posedge clock) disable iff (reset)
      sq_go && close && sq_ctrl.last_all |=> !best_valid_ff && sum_ff == '0)
      else $error("search state not cleared at sequence end");

   a_sum_mono: assert property (@(posedge clock) disable iff (reset)
      sq_go && !close |=> sum_ff >= $past(sum_ff))
      else $error("running sum decreased within a model");

endmodule

`default_nettype wire

>>> rtl/nearest_model_squared_distance_core.sv
// Top level of the nearest model squared distance core.
//
// Usage:
//   req_ch carries one request per cycle while ready is high: a query
//   and a model frequency element (unsigned Q0.FREQ_BITS), the model
//   index and end-of-model / end-of-sequence flags. Each model's squared
//   differences are summed in a 48-bit saturating accumulator.
//   rsp_ch returns one response per request that ends a model: that
//   model's distance, its index, the best model so far and whether any
//   model beat the limit. final_res marks the end of the sequence, after
//   which the search starts over.
//   csr_wr_en / csr_wr_data write distance_limit; write only while idle.
// Pipeline: a request passes the input, square and response registers.
//   Throughput: one request per cycle unless a held response backs it up,
//   set by the single square stage and the single accumulate/compare stage.
// Reset: pipeline empties, the running sum and best model clear and
//   distance_limit returns to all ones.
// Stall: while rsp_ch.ready is low a held response keeps its value;
//   requests that end no model keep flowing, one that ends a model
//   waits in the pipeline, and req_ch.ready drops once it backs up.
`timescale 1ns / 1ps
`default_nettype none

module nearest_model_squared_distance_core #(
   parameter int FREQ_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   nmsd_req_if.sink                   req_ch,
   nmsd_rsp_if.source                 rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire nmsd_pkg::dist_type    csr_wr_data
);
   import nmsd_pkg::*;

   logic                   sq_valid;
   logic                   sq_ready;
   logic [2*FREQ_BITS-1:0] sq_data;
   ctrl_type               sq_ctrl;
   dist_type               limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= DIST_MAX;
      end else if (csr_wr_en) begin
         limit_ff <= csr_wr_data;
      end
   end

   nmsd_square #(
      .FREQ_BITS (FREQ_BITS)
   ) u_square (
      .clock    (clock),
      .reset    (reset),
      .req_ch   (req_ch),
      .sq_valid (sq_valid),
      .sq_ready (sq_ready),
      .sq_data  (sq_data),
      .sq_ctrl  (sq_ctrl)
   );

   nmsd_accum #(
      .FREQ_BITS (FREQ_BITS)
   ) u_accum (
      .clock    (clock),
      .reset    (reset),
      .sq_valid (sq_valid),
      .sq_ready (sq_ready),
      .sq_data  (sq_data),
      .sq_ctrl  (sq_ctrl),
      .limit    (limit_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule

`default_nettype wire

>>> tb/tb_nearest_model_squared_distance_core.sv
// Self-checking testbench for the nearest model squared distance core.
`timescale 1ns / 1ps

module tb_nearest_model_squared_distance_core;
   import nmsd_pkg::*;

   localparam int FREQ_BITS      = 16;
   localparam int RESET_CYCLES   = 8;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 400;
   localparam int DRAIN_CYCLES   = 4;
   localparam int PHASE_ITEMS    = 240;
   localparam int NUM_PHASES     = 8;

   typedef logic [FREQ_BITS-1:0] freq_type;

   typedef struct packed {
      dist_type distance;
      idx_type  finished;
      idx_type  best;
      logic     found;
      logic     closes;
   } verdict_type;

   typedef struct {
      bit          known;
      verdict_type v;
   } tag_type;

   typedef struct {
      bit          is_cfg;
      dist_type    limit;
      freq_type    q;
      freq_type    m;
      idx_type     idx;
      bit          lom;
      bit          loa;
      int          reps;
      bit          known;
      verdict_type v;
   } row_type;

   typedef enum {RSP_FREE, RSP_COIN, RSP_MOSTLY, RSP_CYCLIC, RSP_SPARSE} rsp_mode_type;

   logic     clock = 1'b0;
   logic     reset;
   logic     csr_wr_en;
   dist_type csr_wr_data;

   nmsd_req_if #(.FREQ_BITS(FREQ_BITS)) req_ch ();
   nmsd_rsp_if rsp_ch ();

   nearest_model_squared_distance_core #(.FREQ_BITS(FREQ_BITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always #6 clock = ~clock;

   // search state mirror
   dist_type search_limit;
   dist_type partial_sum;
   dist_type best_dist;
   idx_type  best_idx;
   bit       best_valid;

   verdict_type pending_verdicts[$];
   tag_type     request_tags[$];

   int  errors = 0;
   int  n_sent = 0;
   int  n_requests = 0;
   int  n_responses = 0;
   int  n_seq_ends = 0;
   int  n_saturated = 0;
   int  n_wins = 0;
   int  n_limits = 0;
   int  idle_cycles = 0;
   int  burst_left = 0;
   bit  steady = 1'b0;
   bit  hold_req = 1'b0;
   bit  hold_done = 1'b0;

   function automatic bit advance_search(input freq_type q, m, input idx_type idx,
                                         input logic lom, loa, output verdict_type v);
      freq_type               diff;
      logic [2*FREQ_BITS-1:0] sq;
      logic [DIST_BITS:0]     total;
      v = '0;
      diff = (q >= m) ? q - m : m - q;
      sq = (2*FREQ_BITS)'(diff) * (2*FREQ_BITS)'(diff);
      total = {1'b0, partial_sum} + (DIST_BITS+1)'(sq);
      partial_sum = total[DIST_BITS] ? DIST_MAX : total[DIST_BITS-1:0];
      if (!lom && !loa)
         return 1'b0;
      if (partial_sum < search_limit && (!best_valid || partial_sum < best_dist)) begin
         best_dist  = partial_sum;
         best_idx   = idx;
         best_valid = 1'b1;
      end
      v.distance = partial_sum;
      v.finished = idx;
      v.best     = best_valid ? best_idx : '0;
      v.found    = best_valid;
      v.closes   = loa;
      partial_sum = '0;
      if (loa) begin
         best_dist  = search_limit;
         best_idx   = '0;
         best_valid = 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic flag_field(input string name, input logic [DIST_BITS-1:0] want, got);
      if (got !== want) begin
         errors++;
         $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin : scoreboard
      tag_type     tag;
      verdict_type predicted;
      verdict_type want;
      bit          produced;
      bit          moved;
      if (reset) begin
         search_limit = DIST_MAX;
         partial_sum  = '0;
         best_dist    = DIST_MAX;
         best_idx     = '0;
         best_valid   = 1'b0;
         idle_cycles  = 0;
      end else begin
         moved = 1'b0;
         if (csr_wr_en)
            search_limit = csr_wr_data;
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            n_responses++;
            if (pending_verdicts.size() == 0) begin
               errors++;
               $display("%0t ns: unexpected response, expected none, actual %0h %0h %0h %0b %0b",
                        $time, rsp_ch.model_distance, rsp_ch.finished_model,
                        rsp_ch.best_model, rsp_ch.best_found, rsp_ch.final_res);
            end else begin
               want = pending_verdicts.pop_front();
               flag_field("model_distance", want.distance, rsp_ch.model_distance);
               flag_field("finished_model", DIST_BITS'(want.finished),
                          DIST_BITS'(rsp_ch.finished_model));
               flag_field("best_model", DIST_BITS'(want.best), DIST_BITS'(rsp_ch.best_model));
               flag_field("best_found", DIST_BITS'(want.found), DIST_BITS'(rsp_ch.best_found));
               flag_field("final_res", DIST_BITS'(want.closes), DIST_BITS'(rsp_ch.final_res));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            moved = 1'b1;
            n_requests++;
            tag = request_tags.pop_front();
            produced = advance_search(req_ch.query_freq, req_ch.model_freq, req_ch.model_index,
                                      req_ch.last_of_model, req_ch.last_of_all, predicted);
            if (produced) begin
               pending_verdicts.insert(pending_verdicts.size(), tag.known ? tag.v : predicted);
               if (predicted.closes) n_seq_ends++;
               if (predicted.distance == DIST_MAX) n_saturated++;
               if (predicted.found) n_wins++;
            end
         end
         if (moved || (!req_ch.valid && pending_verdicts.size() == 0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t ns: watchdog, no progress for %0d cycles", $time, idle_cycles);
            $display("tb_nearest_model_squared_distance_core failed");
            $finish;
         end
      end
   end

   // receiver stall patterns plus one long hold-off
   initial begin : rsp_stall_gen
      rsp_mode_type mode;
      int           stretch;
      int           tick;
      rsp_ch.ready = 1'b0;
      tick = 0;
      forever begin
         mode = rsp_mode_type'($urandom_range(0, 4));
         stretch = $urandom_range(10, 120);
         repeat (stretch) begin
            @(negedge clock);
            tick++;
            if (hold_req && !hold_done) begin
               rsp_ch.ready <= 1'b0;
               repeat (HOLD_CYCLES) @(negedge clock);
               hold_done = 1'b1;
            end
            case (mode)
               RSP_FREE:   rsp_ch.ready <= 1'b1;
               RSP_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               RSP_MOSTLY: rsp_ch.ready <= ($urandom_range(0, 4) != 0);
               RSP_CYCLIC: rsp_ch.ready <= ((tick % 3) != 0);
               default:    rsp_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   task automatic send_pair(input freq_type q, m, input idx_type idx, input logic lom, loa,
                            input bit known = 1'b0, input verdict_type v = '0);
      tag_type tag;
      int      gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = steady ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8));
         if (gap > 0) begin
            @(negedge clock);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      tag.known = known;
      tag.v = v;
      request_tags.insert(request_tags.size(), tag);
      @(negedge clock);
      req_ch.valid         <= 1'b1;
      req_ch.query_freq    <= q;
      req_ch.model_freq    <= m;
      req_ch.model_index   <= idx;
      req_ch.last_of_model <= lom;
      req_ch.last_of_all   <= loa;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      n_sent++;
   endtask

   task automatic write_limit(input dist_type value);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      burst_left = 0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      n_limits++;
   endtask

   function automatic freq_type pick_freq();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return freq_type'($urandom_range(0, 255));
         default: return freq_type'($urandom);
      endcase
   endfunction

   // well-formed sequence of models; a broken one drops a closing element
   task automatic run_sequence(input bit broken);
      freq_type qs[$];
      freq_type ms[$];
      freq_type pq[$];
      freq_type pm[$];
      freq_type q;
      freq_type m;
      int       n_models;
      int       len;
      int       stop_model;
      idx_type  idx;
      bit       lom;
      bit       loa;
      bit       last_elem;
      n_models = $urandom_range(1, 6);
      idx = idx_type'($urandom);
      stop_model = broken ? $urandom_range(0, n_models - 1) : n_models;
      for (int k = 0; k < n_models; k++) begin
         if (pq.size() != 0 && $urandom_range(0, 5) == 0) begin
            qs = pq;
            ms = pm;
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            qs.delete();
            ms.delete();
            for (int e = 0; e < len; e++) begin
               q = pick_freq();
               m = ($urandom_range(0, 3) == 0) ? q ^ freq_type'($urandom_range(0, 15))
                                                : pick_freq();
               qs.insert(qs.size(), q);
               ms.insert(ms.size(), m);
            end
         end
         for (int e = 0; e < qs.size(); e++) begin
            last_elem = (e == qs.size() - 1);
            if (k == stop_model && last_elem)
               return;
            loa = last_elem && (k == n_models - 1);
            lom = loa ? 1'($urandom_range(0, 1)) : last_elem;
            send_pair(qs[e], ms[e], idx, lom, loa);
         end
         pq = qs;
         pm = ms;
         idx = ($urandom_range(0, 3) == 0) ? idx_type'($urandom) : idx + 1'b1;
      end
   endtask

   task automatic send_noise(input int count);
      repeat (count)
         send_pair(freq_type'($urandom), freq_type'($urandom), idx_type'($urandom),
                   $urandom_range(0, 3) == 0, $urandom_range(0, 15) == 0);
   endtask

   initial begin : stimulus
      row_type  rows [18];
      dist_type lim;
      int       phase_start;
      reset                = 1'b1;
      csr_wr_en            = 1'b0;
      csr_wr_data          = '0;
      req_ch.valid         = 1'b0;
      req_ch.query_freq    = '0;
      req_ch.model_freq    = '0;
      req_ch.model_index   = '0;
      req_ch.last_of_model = 1'b0;
      req_ch.last_of_all   = 1'b0;
      rows = '{
         '{0, '0, 16'h0000, 16'h0000, 4'd0, 1, 0, 1, 1, '{48'h0, 4'd0, 4'd0, 1'b1, 1'b0}},
         '{0, '0, 16'hFFFF, 16'h0000, 4'd15, 1, 0, 1, 1,
           '{48'hFFFE0001, 4'd15, 4'd0, 1'b1, 1'b0}},
         '{0, '0, 16'h0000, 16'hFFFF, 4'd5, 0, 1, 1, 1,
           '{48'hFFFE0001, 4'd5, 4'd0, 1'b1, 1'b1}},
         '{0, '0, 16'h1234, 16'h1234, 4'd3, 0, 0, 1, 0, '0},
         '{0, '0, 16'hABCD, 16'h5432, 4'd3, 1, 0, 1, 0, '0},
         '{0, '0, 16'h5432, 16'hABCD, 4'd7, 1, 0, 1, 0, '0},
         '{0, '0, 16'h8000, 16'h7FFF, 4'd9, 1, 0, 1, 0, '0},
         '{0, '0, 16'h0000, 16'h0000, 4'd2, 1, 1, 1, 0, '0},
         '{1, 48'h0, 16'h0000, 16'h0000, 4'd0, 0, 0, 0, 0, '0},
         '{0, '0, 16'h0000, 16'h0000, 4'd4, 1, 1, 1, 1, '{48'h0, 4'd4, 4'd0, 1'b0, 1'b1}},
         '{1, 48'h1_0000_0000, 16'h0000, 16'h0000, 4'd0, 0, 0, 0, 0, '0},
         '{0, '0, 16'hFFFF, 16'h0000, 4'd1, 1, 0, 1, 1,
           '{48'hFFFE0001, 4'd1, 4'd1, 1'b1, 1'b0}},
         '{0, '0, 16'hAAAA, 16'h5555, 4'd6, 0, 0, 1, 0, '0},
         '{0, '0, 16'h5555, 16'hAAAA, 4'd6, 1, 0, 1, 0, '0},
         '{1, 48'h0, 16'h0000, 16'h0000, 4'd0, 0, 0, 0, 0, '0},
         '{0, '0, 16'h0000, 16'h0000, 4'd8, 1, 1, 1, 1, '{48'h0, 4'd8, 4'd6, 1'b1, 1'b1}},
         '{1, DIST_MAX, 16'h0000, 16'h0000, 4'd0, 0, 0, 0, 0, '0},
         '{0, '0, 16'hFFFF, 16'hFFFF, 4'd15, 1, 1, 1, 1,
           '{48'h0, 4'd15, 4'd15, 1'b1, 1'b1}}
      };
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[r]) begin
         if (rows[r].is_cfg) begin
            write_limit(rows[r].limit);
         end else begin
            for (int k = 1; k < rows[r].reps; k++)
               send_pair(rows[r].q, rows[r].m, rows[r].idx, 1'b0, 1'b0);
            send_pair(rows[r].q, rows[r].m, rows[r].idx, rows[r].lom, rows[r].loa,
                      rows[r].known, rows[r].v);
         end
      end

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: lim = DIST_MAX;
            1: lim = dist_type'({$urandom, $urandom}) >> 13;
            2: lim = '0;
            3: lim = dist_type'(1);
            4: lim = dist_type'({$urandom, $urandom});
            5: lim = dist_type'({$urandom, $urandom}) >> 15;
            6: lim = dist_type'({$urandom, $urandom}) >> 11;
            default: lim = DIST_MAX;
         endcase
         write_limit(lim);
         steady = (ph % 3 == 2);
         if (ph == 1)
            hold_req = 1'b1;
         phase_start = n_sent;
         while (n_sent - phase_start < PHASE_ITEMS) begin
            if ($urandom_range(0, 9) == 0)
               send_noise($urandom_range(1, 4));
            else
               run_sequence($urandom_range(0, 7) == 0);
         end
      end

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (2 * DRAIN_CYCLES) @(posedge clock);
      $display("Run covered %0d requests and %0d responses under %0d limit settings",
               n_requests, n_responses, n_limits);
      $display("  %0d sequence ends, %0d saturated sums, %0d responses with a winner",
               n_seq_ends, n_saturated, n_wins);
      if (errors == 0 && pending_verdicts.size() == 0)
         $display("tb_nearest_model_squared_distance_core passed");
      else
         $display("tb_nearest_model_squared_distance_core failed");
      $finish;
   end

endmodule
